// ===== hdl/priority_task_queue_assert.svh =====
// Assertion macros for the priority task queue.
`ifndef PRIORITY_TASK_QUEUE_ASSERT_SVH
`define PRIORITY_TASK_QUEUE_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define PTQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that the consequent holds whenever the antecedent holds.
`define PTQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define PTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ptq_pkg.sv =====
`default_nettype none

package ptq_pkg;

    localparam int DEF_QUEUE_DEPTH   = 16;
    localparam int DEF_MAX_ACTIVE    = 8;
    localparam int DEF_PRIORITY_BITS = 3;
    localparam int DEF_TAG_BITS      = 32;

    typedef enum logic [1:0] {
        CMD_SUBMIT   = 2'd0,
        CMD_TAKE     = 2'd1,
        CMD_DONE     = 2'd2,
        CMD_SHUTDOWN = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_FULL        = 3'd1,
        ST_REJECTED    = 3'd2,
        ST_EMPTY       = 3'd3,
        ST_EXIT        = 3'd4,
        ST_NONE_ACTIVE = 3'd5
    } t_status;

    typedef struct packed {
        logic insert;
        logic take;
    } t_cell_op;

endpackage

`default_nettype wire

// ===== hdl/ptq_cell.sv =====
`default_nettype none

module ptq_cell
    import ptq_pkg::*;
#(
    parameter int INDEX         = 0,
    parameter int COUNT_BITS    = 5,
    parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
    parameter int TAG_BITS      = DEF_TAG_BITS
) (
    input  wire logic                     i_clk,
    input  wire t_cell_op                 i_op,
    input  wire logic [COUNT_BITS-1:0]    i_count,
    input  wire logic [TAG_BITS-1:0]      i_new_tag,
    input  wire logic [PRIORITY_BITS-1:0] i_new_priority,
    input  wire logic                     i_left_go,
    input  wire logic [TAG_BITS-1:0]      i_left_tag,
    input  wire logic [PRIORITY_BITS-1:0] i_left_priority,
    input  wire logic [TAG_BITS-1:0]      i_right_tag,
    input  wire logic [PRIORITY_BITS-1:0] i_right_priority,
    output logic                          o_go,
    output logic [TAG_BITS-1:0]           o_tag,
    output logic [PRIORITY_BITS-1:0]      o_priority
);

    logic [TAG_BITS-1:0]      r_tag;
    logic [PRIORITY_BITS-1:0] r_priority;
    logic [TAG_BITS-1:0]      n_tag;
    logic [PRIORITY_BITS-1:0] n_priority;
    logic                     w_occupied;

    assign w_occupied = COUNT_BITS'(INDEX) < i_count;
    assign o_go       = !w_occupied || (r_priority < i_new_priority);
    assign o_tag      = r_tag;
    assign o_priority = r_priority;

    always_comb begin
        n_tag      = r_tag;
        n_priority = r_priority;
        if (i_op.insert) begin
            if (i_left_go) begin
                n_tag      = i_left_tag;
                n_priority = i_left_priority;
            end else if (o_go) begin
                n_tag      = i_new_tag;
                n_priority = i_new_priority;
            end
        end else if (i_op.take) begin
            n_tag      = i_right_tag;
            n_priority = i_right_priority;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag      <= n_tag;
        r_priority <= n_priority;
    end

endmodule

`default_nettype wire

// ===== hdl/priority_task_queue.sv =====
// A command's result is registered and appears in the cycle after its transfer.
// Throughput: one command per cycle while o_in_stall is low; every cell of the sorted chain updates in the same cycle.
// A waiting result does not block input while it is being taken in the same cycle.
// Reset (synchronous, active low) clears the counts, the shutdown flag and the output valid.
// The cell store is not cleared; only occupied cells are ever read.
`default_nettype none

`include "priority_task_queue_assert.svh"

module priority_task_queue
    import ptq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
    parameter int MAX_ACTIVE    = DEF_MAX_ACTIVE,
    parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
    parameter int TAG_BITS      = DEF_TAG_BITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic [1:0]                            i_cmd,
    input  wire logic [TAG_BITS-1:0]                   i_task_tag,
    input  wire logic [PRIORITY_BITS-1:0]              i_task_priority,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic [2:0]                                 o_status,
    output logic [TAG_BITS-1:0]                        o_taken_tag,
    output logic [PRIORITY_BITS-1:0]                   o_taken_priority,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]           o_queue_count,
    output logic [$clog2(MAX_ACTIVE+1)-1:0]            o_active_count,
    output logic                                       o_idle
);

    localparam int QW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(MAX_ACTIVE + 1);

    logic                     w_go       [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]      w_tag      [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] w_priority [QUEUE_DEPTH];

    logic [QW-1:0]            r_count;
    logic [QW-1:0]            n_count;
    logic [AW-1:0]            r_busy;
    logic [AW-1:0]            n_busy;
    logic                     r_stopping;
    logic                     n_stopping;

    logic                     r_out_valid;
    t_status                  r_status;
    t_status                  n_status;
    logic [TAG_BITS-1:0]      r_taken_tag;
    logic [TAG_BITS-1:0]      n_taken_tag;
    logic [PRIORITY_BITS-1:0] r_taken_priority;
    logic [PRIORITY_BITS-1:0] n_taken_priority;
    logic                     r_idle;
    logic [QW-1:0]            r_out_count;
    logic [AW-1:0]            r_out_busy;

    logic                     w_accept;
    t_cell_op                 w_op;
    t_cell_op                 w_cell_op;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        w_op             = '0;
        n_count          = r_count;
        n_busy           = r_busy;
        n_stopping       = r_stopping;
        n_status         = ST_OK;
        n_taken_tag      = '0;
        n_taken_priority = '0;
        case (t_cmd'(i_cmd))
            CMD_SUBMIT: begin
                if (r_stopping) begin
                    n_status = ST_REJECTED;
                end else if (r_count == QW'(QUEUE_DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    w_op.insert = 1'b1;
                    n_count     = r_count + 1'b1;
                end
            end
            CMD_TAKE: begin
                if (r_count == '0) begin
                    n_status = r_stopping ? ST_EXIT : ST_EMPTY;
                end else begin
                    w_op.take        = 1'b1;
                    n_taken_tag      = w_tag[0];
                    n_taken_priority = w_priority[0];
                    n_count          = r_count - 1'b1;
                    if (r_busy < AW'(MAX_ACTIVE)) begin
                        n_busy = r_busy + 1'b1;
                    end
                end
            end
            CMD_DONE: begin
                if (r_busy == '0) begin
                    n_status = ST_NONE_ACTIVE;
                end else begin
                    n_busy = r_busy - 1'b1;
                end
            end
            CMD_SHUTDOWN: begin
                n_stopping = 1'b1;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    assign w_cell_op = w_accept ? w_op : '0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic                     w_left_go;
        logic [TAG_BITS-1:0]      w_left_tag;
        logic [PRIORITY_BITS-1:0] w_left_priority;
        logic [TAG_BITS-1:0]      w_right_tag;
        logic [PRIORITY_BITS-1:0] w_right_priority;

        if (g == 0) begin : g_first
            assign w_left_go       = 1'b0;
            assign w_left_tag      = i_task_tag;
            assign w_left_priority = i_task_priority;
        end else begin : g_inner
            assign w_left_go       = w_go[g-1];
            assign w_left_tag      = w_tag[g-1];
            assign w_left_priority = w_priority[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_right_tag      = w_tag[g];
            assign w_right_priority = w_priority[g];
        end else begin : g_next
            assign w_right_tag      = w_tag[g+1];
            assign w_right_priority = w_priority[g+1];
        end

        ptq_cell #(
            .INDEX         (g),
            .COUNT_BITS    (QW),
            .PRIORITY_BITS (PRIORITY_BITS),
            .TAG_BITS      (TAG_BITS)
        ) u_cell (
            .i_clk            (i_clk),
            .i_op             (w_cell_op),
            .i_count          (r_count),
            .i_new_tag        (i_task_tag),
            .i_new_priority   (i_task_priority),
            .i_left_go        (w_left_go),
            .i_left_tag       (w_left_tag),
            .i_left_priority  (w_left_priority),
            .i_right_tag      (w_right_tag),
            .i_right_priority (w_right_priority),
            .o_go             (w_go[g]),
            .o_tag            (w_tag[g]),
            .o_priority       (w_priority[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_busy      <= '0;
            r_stopping  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_busy      <= n_busy;
                r_stopping  <= n_stopping;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status         <= n_status;
            r_taken_tag      <= n_taken_tag;
            r_taken_priority <= n_taken_priority;
            r_out_count      <= n_count;
            r_out_busy       <= n_busy;
            r_idle           <= (n_count == '0) && (n_busy == '0);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_taken_tag      = r_taken_tag;
    assign o_taken_priority = r_taken_priority;
    assign o_queue_count    = r_out_count;
    assign o_active_count   = r_out_busy;
    assign o_idle           = r_idle;

    `PTQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= QW'(QUEUE_DEPTH), "queue count over depth")
    `PTQ_ASSERT(a_busy_bound, i_clk, i_rst_n, r_busy <= AW'(MAX_ACTIVE), "active count over limit")
    `PTQ_ASSERT_NEXT(a_stop_sticky, i_clk, i_rst_n, r_stopping, r_stopping, "shutdown flag cleared")
    `PTQ_ASSERT_IMPL(a_taken_zero, i_clk, i_rst_n,
                     r_out_valid && (r_status != ST_OK),
                     (r_taken_tag == '0) && (r_taken_priority == '0),
                     "taken task on failed command")
    `PTQ_ASSERT_IMPL(a_idle_match, i_clk, i_rst_n, r_out_valid,
                     r_idle == ((r_out_count == '0) && (r_out_busy == '0)),
                     "idle flag mismatch")

endmodule

`default_nettype wire

// ===== tb/sv/priority_task_queue_tb.sv =====
`default_nettype none

module priority_task_queue_tb;
    import ptq_pkg::*;

    localparam int TAG_W       = DEF_TAG_BITS;
    localparam int PRI_W       = DEF_PRIORITY_BITS;
    localparam int QCNT_W      = $clog2(DEF_QUEUE_DEPTH + 1);
    localparam int ACNT_W      = $clog2(DEF_MAX_ACTIVE + 1);
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [TAG_W-1:0] tag;
        logic [PRI_W-1:0] pri;
    } t_task;

    typedef struct {
        t_status           status;
        logic [TAG_W-1:0]  taken_tag;
        logic [PRI_W-1:0]  taken_priority;
        logic [QCNT_W-1:0] queue_count;
        logic [ACNT_W-1:0] active_count;
        logic              idle;
    } t_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_cmd = CMD_SUBMIT;
    logic [TAG_W-1:0]  i_task_tag = '0;
    logic [PRI_W-1:0]  i_task_priority = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [2:0]        o_status;
    logic [TAG_W-1:0]  o_taken_tag;
    logic [PRI_W-1:0]  o_taken_priority;
    logic [QCNT_W-1:0] o_queue_count;
    logic [ACNT_W-1:0] o_active_count;
    logic              o_idle;

    t_task   pending_tasks[$];
    int      busy_workers;
    bit      shut_down;
    t_result expected_results[$];

    bit idle_enable = 1'b1;
    int mismatches;
    int commands_sent;
    int results_seen;
    int saturated_takes;
    int status_seen[6];
    int cycle_count;

    priority_task_queue dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_task_tag       (i_task_tag),
        .i_task_priority  (i_task_priority),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_taken_tag      (o_taken_tag),
        .o_taken_priority (o_taken_priority),
        .o_queue_count    (o_queue_count),
        .o_active_count   (o_active_count),
        .o_idle           (o_idle)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        if (!idle_enable) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return TAG_W'($urandom);
    endfunction

    function automatic t_result predict_command(t_cmd c, logic [TAG_W-1:0] tag,
                                                logic [PRI_W-1:0] pri);
        t_result r;
        t_task   entry;
        int      slot;
        r.status         = ST_OK;
        r.taken_tag      = '0;
        r.taken_priority = '0;
        case (c)
            CMD_SUBMIT: begin
                if (shut_down) begin
                    r.status = ST_REJECTED;
                end else if (pending_tasks.size() >= DEF_QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    entry.tag = tag;
                    entry.pri = pri;
                    slot = pending_tasks.size();
                    for (int i = 0; i < pending_tasks.size(); i++) begin
                        if (pending_tasks[i].pri < pri) begin
                            slot = i;
                            break;
                        end
                    end
                    pending_tasks.insert(slot, entry);
                end
            end
            CMD_TAKE: begin
                if (pending_tasks.size() == 0) begin
                    r.status = shut_down ? ST_EXIT : ST_EMPTY;
                end else begin
                    entry = pending_tasks.pop_front();
                    r.taken_tag      = entry.tag;
                    r.taken_priority = entry.pri;
                    if (busy_workers < DEF_MAX_ACTIVE) busy_workers++;
                    else saturated_takes++;
                end
            end
            CMD_DONE: begin
                if (busy_workers == 0) r.status = ST_NONE_ACTIVE;
                else busy_workers--;
            end
            default: begin
                shut_down = 1'b1;
            end
        endcase
        r.queue_count  = QCNT_W'(pending_tasks.size());
        r.active_count = ACNT_W'(busy_workers);
        r.idle         = (pending_tasks.size() == 0) && (busy_workers == 0);
        return r;
    endfunction

    task automatic send_command(t_cmd c, logic [TAG_W-1:0] tag, logic [PRI_W-1:0] pri);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_cmd           <= c;
        i_task_tag      <= tag;
        i_task_priority <= pri;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        expected_results.push_back(predict_command(c, tag, pri));
        commands_sent++;
    endtask

    initial begin : out_stall_gen
        int run;
        forever begin
            run = pick_gap();
            if (run > 0) begin
                i_out_stall <= 1'b1;
                repeat (run) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            run = $urandom_range(1, 6);
            repeat (run) @(posedge i_clk);
        end
    end

    task automatic check_field(string name, logic [TAG_W-1:0] want, logic [TAG_W-1:0] got);
        if (got !== want) begin
            $error("%s expected 0x%0h got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            results_seen++;
            if (o_status < 6) status_seen[o_status]++;
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected, status %0d", o_status);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", TAG_W'(want.status), TAG_W'(o_status));
                check_field("taken_tag", want.taken_tag, o_taken_tag);
                check_field("taken_priority", TAG_W'(want.taken_priority),
                            TAG_W'(o_taken_priority));
                check_field("queue_count", TAG_W'(want.queue_count), TAG_W'(o_queue_count));
                check_field("active_count", TAG_W'(want.active_count),
                            TAG_W'(o_active_count));
                check_field("idle", TAG_W'(want.idle), TAG_W'(o_idle));
            end
        end
    end

    task automatic test_empty_queue();
        send_command(CMD_TAKE, pick_tag(), 3'd5);
        send_command(CMD_DONE, '1, '1);
    endtask

    task automatic test_fill_order_saturate();
        logic [PRI_W-1:0] pris[16] = '{7, 0, 3, 3, 7, 0, 5, 1, 2, 6, 4, 3, 7, 0, 1, 6};
        logic [TAG_W-1:0] tag;
        for (int i = 0; i < 16; i++) begin
            case (i)
                0:       tag = '0;
                1:       tag = '1;
                2:       tag = 32'hAAAA_AAAA;
                3:       tag = 32'h5555_5555;
                default: tag = TAG_W'($urandom);
            endcase
            send_command(CMD_SUBMIT, tag, pris[i]);
        end
        send_command(CMD_SUBMIT, 32'hDEAD_0001, 3'd7);
        repeat (9) send_command(CMD_TAKE, '0, '0);
    endtask

    task automatic test_random_traffic(int n_items);
        int   sent;
        int   burst;
        int   mode;
        int   roll;
        t_cmd c;
        logic [PRI_W-1:0] pri;
        sent = 0;
        while (sent < n_items) begin
            burst       = $urandom_range(10, 40);
            mode        = $urandom_range(0, 3);
            idle_enable = ($urandom_range(0, 3) != 0);
            repeat (burst) begin
                roll = $urandom_range(0, 99);
                case (mode)
                    0:       c = roll < 70 ? CMD_SUBMIT : (roll < 85 ? CMD_TAKE : CMD_DONE);
                    1:       c = roll < 15 ? CMD_SUBMIT : (roll < 75 ? CMD_TAKE : CMD_DONE);
                    2:       c = roll < 25 ? CMD_SUBMIT : (roll < 45 ? CMD_TAKE : CMD_DONE);
                    default: c = roll < 34 ? CMD_SUBMIT : (roll < 67 ? CMD_TAKE : CMD_DONE);
                endcase
                pri = ($urandom_range(0, 3) == 0) ? PRI_W'($urandom_range(2, 3))
                                                  : PRI_W'($urandom);
                send_command(c, pick_tag(), pri);
                sent++;
            end
        end
        idle_enable = 1'b1;
    endtask

    task automatic test_shutdown_drain();
        send_command(CMD_SHUTDOWN, pick_tag(), PRI_W'($urandom));
        send_command(CMD_SHUTDOWN, pick_tag(), PRI_W'($urandom));
        send_command(CMD_SUBMIT, '1, '1);
        while (pending_tasks.size() != 0) send_command(CMD_TAKE, pick_tag(), '0);
        send_command(CMD_TAKE, '0, '0);
        while (busy_workers != 0) send_command(CMD_DONE, pick_tag(), '0);
        send_command(CMD_DONE, '0, '0);
        repeat (30) send_command(t_cmd'($urandom_range(0, 3)), pick_tag(), PRI_W'($urandom));
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_fill_order_saturate();
        test_random_traffic(500);
        test_shutdown_drain();
        i_in_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("%0d commands, %0d results checked; %0d takes at the active ceiling",
                 commands_sent, results_seen, saturated_takes);
        $display("status counts: ok %0d full %0d rejected %0d empty %0d exit %0d idle-done %0d",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_REJECTED],
                 status_seen[ST_EMPTY], status_seen[ST_EXIT], status_seen[ST_NONE_ACTIVE]);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/ptq_pkg.sv
hdl/ptq_cell.sv
hdl/priority_task_queue.sv
tb/sv/priority_task_queue_tb.sv
